FILE: rtl/matrix3_inverse_adjugate_defines.svh
// assertion macros for the matrix inverse block
`ifndef MATRIX3_INVERSE_ADJUGATE_DEFINES_SVH
`define MATRIX3_INVERSE_ADJUGATE_DEFINES_SVH

`define M3I_ASSERT_IMPL(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("%m: label failed");

`define M3I_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("%m: label failed");

`endif

FILE: rtl/m3inv_pkg.sv
`timescale 1ns / 1ps
package m3inv_pkg;
   localparam int ELEM_W  = 16;
   localparam int MINOR_W = 33;
   localparam int DET_W   = 49;
   localparam int NUM_W   = 57;
   localparam int OUT_W   = 32;
   localparam int N_ELEM  = 9;
   localparam int FRAC_SHIFT = 24;
   localparam int DIV_STEPS = NUM_W;

   typedef logic signed [ELEM_W-1:0]  elem_type;
   typedef logic signed [MINOR_W-1:0] minor_type;
   typedef logic signed [DET_W-1:0]   det_type;
   typedef logic signed [OUT_W-1:0]   out_type;

   typedef struct packed {
      logic singular;
      logic clipped;
   } flags_type;

   localparam logic signed [OUT_W-1:0] SAT_HI = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic signed [OUT_W-1:0] SAT_LO = {1'b1, {(OUT_W-1){1'b0}}};
endpackage

FILE: rtl/matrix3_inverse_adjugate.sv
`timescale 1ns / 1ps
// 3x3 matrix inverse by the adjugate, Q8.8 in, Q16.16 out
// req_tdata: nine signed 16-bit elements, column-major, a_r0c0 in the low bits
// rsp_tdata: nine signed 32-bit inverse elements in the same order, 288 bits
// rsp_tuser: singular at bit 0, clipped at bit 1
// a zero determinant gives singular with all elements zero
// throughput: one matrix per cycle; a transfer on req is taken every cycle
//    that the pipeline is not stalled
// path from req transfer to rsp_tvalid: four adjugate stages, then per lane
//    an operand register, the 57-stage quotient pipeline and a magnitude
//    register, and then the output register
// nine divider lanes run side by side, one per element
// a stall on rsp_tready freezes the whole pipeline; req_tready drops
//    whenever the output register holds a result that is not taken
// reset clears all valid flags; no result is produced out of reset
module matrix3_inverse_adjugate (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [143:0] req_tdata, // a_r0c0,a_r1c0,a_r2c0,a_r0c1,..,a_r2c2
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [287:0] rsp_tdata, // inv_r0c0..inv_r2c2
   output logic [1:0] rsp_tuser // singular, clipped
);
   import m3inv_pkg::*;

   localparam int LAT = DIV_STEPS + 2;

   logic advance;
   elem_type a [9];
   minor_type adj [9];
   det_type det;
   logic adj_valid;
   out_type q [9];
   logic [8:0] clip;
   logic [LAT-1:0] dv_ff;
   logic [LAT-1:0] dz_ff;
   logic [287:0] merged;
   flags_type flags;
   logic [287:0] data_ff;
   logic [1:0] user_ff;
   logic valid_ff;

   assign advance = !valid_ff || rsp_tready;
   assign req_tready = advance;

   always_comb for (int i = 0; i < 9; i++) a[i] = elem_type'(req_tdata[i*ELEM_W +: ELEM_W]);

   m3inv_adjugate u_adj (
      .clock(clock), .reset(reset), .advance(advance), .a_in(a),
      .valid_in(req_tvalid && advance), .adj_out(adj), .det_out(det),
      .valid_out(adj_valid)
   );

   for (genvar g = 0; g < 9; g++) begin : g_lane
      m3inv_div_lane u_lane (
         .clock(clock), .advance(advance), .adj_in(adj[g]), .det_in(det),
         .q_out(q[g]), .clip_out(clip[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) dv_ff <= '0;
      else if (advance) dv_ff <= {dv_ff[LAT-2:0], adj_valid};
   end
   always_ff @(posedge clock) if (advance) dz_ff <= {dz_ff[LAT-2:0], det == '0};

   m3inv_merge u_merge (
      .q_in(q), .clip_in(clip), .det_zero(dz_ff[LAT-1]),
      .data_out(merged), .flags_out(flags)
   );

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (advance) valid_ff <= dv_ff[LAT-1];
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= merged;
         user_ff <= {flags.clipped, flags.singular};
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata = data_ff;
   assign rsp_tuser = user_ff;
endmodule

FILE: rtl/m3inv_adjugate.sv
`timescale 1ns / 1ps
// one pipelined stage set forming the adjugate and determinant
module m3inv_adjugate (
   input  logic clock,
   input  logic reset,
   input  logic advance,
   input  m3inv_pkg::elem_type a_in [9],
   input  logic valid_in,
   output m3inv_pkg::minor_type adj_out [9],
   output m3inv_pkg::det_type det_out,
   output logic valid_out
);
   import m3inv_pkg::*;

   // a_in column-major: index c*3+r
   minor_type p1_ff [9];
   minor_type p2_ff [9];
   minor_type adj_ff [9];
   elem_type  a_ff [9];
   elem_type  a2_ff [9];
   logic [3:0] vp_ff;
   det_type t0_ff, t1_ff, t2_ff;
   det_type det_ff;
   minor_type adj2_ff [9];

   function automatic minor_type mul(elem_type x, elem_type y);
      logic signed [31:0] p;
      p = x * y;
      return minor_type'(p);
   endfunction

   // index helper m[r][c] = a_in[c*3+r]
   always_ff @(posedge clock) begin
      if (advance) begin
         // stage 1: products
         p1_ff[0] <= mul(a_in[4], a_in[8]); p2_ff[0] <= mul(a_in[7], a_in[5]);
         p1_ff[1] <= mul(a_in[6], a_in[5]); p2_ff[1] <= mul(a_in[3], a_in[8]);
         p1_ff[2] <= mul(a_in[3], a_in[7]); p2_ff[2] <= mul(a_in[6], a_in[4]);
         p1_ff[3] <= mul(a_in[7], a_in[2]); p2_ff[3] <= mul(a_in[1], a_in[8]);
         p1_ff[4] <= mul(a_in[0], a_in[8]); p2_ff[4] <= mul(a_in[6], a_in[2]);
         p1_ff[5] <= mul(a_in[6], a_in[1]); p2_ff[5] <= mul(a_in[0], a_in[7]);
         p1_ff[6] <= mul(a_in[1], a_in[5]); p2_ff[6] <= mul(a_in[4], a_in[2]);
         p1_ff[7] <= mul(a_in[3], a_in[2]); p2_ff[7] <= mul(a_in[0], a_in[5]);
         p1_ff[8] <= mul(a_in[0], a_in[4]); p2_ff[8] <= mul(a_in[3], a_in[1]);
         for (int i = 0; i < 9; i++) a_ff[i] <= a_in[i];
         // stage 2: minors, adj[r][c] stored at c*3+r
         adj_ff[0] <= p1_ff[0] - p2_ff[0];
         adj_ff[3] <= p1_ff[1] - p2_ff[1];
         adj_ff[6] <= p1_ff[2] - p2_ff[2];
         adj_ff[1] <= p1_ff[3] - p2_ff[3];
         adj_ff[4] <= p1_ff[4] - p2_ff[4];
         adj_ff[7] <= p1_ff[5] - p2_ff[5];
         adj_ff[2] <= p1_ff[6] - p2_ff[6];
         adj_ff[5] <= p1_ff[7] - p2_ff[7];
         adj_ff[8] <= p1_ff[8] - p2_ff[8];
         // stage 3: row 0 cofactor products
         t0_ff <= det_type'(a2_ff[0] * adj_ff[0]);
         t1_ff <= det_type'(a2_ff[3] * adj_ff[1]);
         t2_ff <= det_type'(a2_ff[6] * adj_ff[2]);
         for (int i = 0; i < 9; i++) adj2_ff[i] <= adj_ff[i];
         det_ff <= t0_ff + t1_ff + t2_ff;
         for (int i = 0; i < 9; i++) adj_out[i] <= adj2_ff[i];
      end
   end

   // a_ff is registered alongside p1_ff; a2_ff realigns a with adj_ff for stage 3
   always_ff @(posedge clock) if (advance) for (int i = 0; i < 9; i++) a2_ff[i] <= a_ff[i];

   always_ff @(posedge clock) begin
      if (reset) vp_ff <= '0;
      else if (advance) vp_ff <= {vp_ff[2:0], valid_in};
   end
   assign det_out = det_ff;
   assign valid_out = vp_ff[3];
endmodule

FILE: rtl/m3inv_div_lane.sv
`timescale 1ns / 1ps
// pipelined restoring divider lane, one quotient bit per stage
module m3inv_div_lane (
   input  logic clock,
   input  logic advance,
   input  m3inv_pkg::minor_type adj_in,
   input  m3inv_pkg::det_type det_in,
   output m3inv_pkg::out_type q_out,
   output logic clip_out
);
   import m3inv_pkg::*;

   localparam int N = DIV_STEPS;
   localparam int DW = DET_W;

   logic [N-1:0]  num_ff [N+1];
   logic [DW:0]   rem_ff [N+1];
   logic [DW-1:0] den_ff [N+1];
   logic          neg_ff [N+1];
   logic [N-1:0]  mag_ff;
   logic          sgn_ff;
   logic signed [NUM_W:0] sq;

   logic signed [NUM_W-1:0] num_s;
   assign num_s = NUM_W'(adj_in) <<< FRAC_SHIFT;

   always_ff @(posedge clock) begin
      if (advance) begin
         num_ff[0] <= num_s[NUM_W-1] ? NUM_W'(-num_s) : NUM_W'(num_s);
         den_ff[0] <= det_in[DW-1] ? DW'(-det_in) : DW'(det_in);
         neg_ff[0] <= num_s[NUM_W-1] ^ det_in[DW-1];
         rem_ff[0] <= '0;
         for (int i = 0; i < N; i++) begin
            logic [DW:0] r;
            r = {rem_ff[i][DW-1:0], num_ff[i][N-1]};
            if (r >= {1'b0, den_ff[i]}) begin
               rem_ff[i+1] <= r - {1'b0, den_ff[i]};
               num_ff[i+1] <= {num_ff[i][N-2:0], 1'b1};
            end else begin
               rem_ff[i+1] <= r;
               num_ff[i+1] <= {num_ff[i][N-2:0], 1'b0};
            end
            den_ff[i+1] <= den_ff[i];
            neg_ff[i+1] <= neg_ff[i];
         end
         mag_ff <= num_ff[N];
         sgn_ff <= neg_ff[N];
      end
   end

   assign sq = sgn_ff ? -$signed({1'b0, mag_ff}) : $signed({1'b0, mag_ff});

   always_comb begin
      clip_out = 1'b0;
      q_out = out_type'(sq);
      if (sq > $signed({{(NUM_W-OUT_W+1){1'b0}}, SAT_HI})) begin
         q_out = SAT_HI; clip_out = 1'b1;
      end else if (sq < $signed({{(NUM_W-OUT_W+1){1'b1}}, SAT_LO})) begin
         q_out = SAT_LO; clip_out = 1'b1;
      end
   end
endmodule

FILE: rtl/m3inv_merge.sv
`timescale 1ns / 1ps
// combines the lane results and the singular check into one result word
module m3inv_merge (
   input  m3inv_pkg::out_type q_in [9],
   input  logic [8:0] clip_in,
   input  logic det_zero,
   output logic [287:0] data_out,
   output m3inv_pkg::flags_type flags_out
);
   import m3inv_pkg::*;

   always_comb begin
      data_out = '0;
      for (int i = 0; i < N_ELEM; i++)
         data_out[i*OUT_W +: OUT_W] = det_zero ? '0 : q_in[i];
      flags_out.singular = det_zero;
      flags_out.clipped  = !det_zero && (|clip_in);
   end
endmodule

FILE: rtl/m3inv_checker.sv
`timescale 1ns / 1ps
`include "matrix3_inverse_adjugate_defines.svh"
module m3inv_checker (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [287:0] rsp_tdata,
   input logic [1:0] rsp_tuser
);
   `M3I_ASSERT_IMPL(a_singular_zero, clock, reset, rsp_tvalid && rsp_tuser[0],
      rsp_tdata == '0 && !rsp_tuser[1])
   `M3I_ASSERT_IMPL(a_ready_free, clock, reset, !rsp_tvalid, req_tready)
   `M3I_ASSERT_NEXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
endmodule

bind matrix3_inverse_adjugate m3inv_checker u_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
   .rsp_tuser(rsp_tuser)
);

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
   import m3inv_pkg::*;

   localparam int LATENCY = 63;
   localparam longint MAX_CYCLES = 600000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [143:0] req_tdata = '0; // a_r0c0,a_r1c0,a_r2c0,a_r0c1,..,a_r2c2
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [287:0] rsp_tdata; // inv_r0c0..inv_r2c2
   logic [1:0] rsp_tuser; // singular, clipped

   // expected: elements in 287:0, singular at 288, clipped at 289
   logic [289:0] inverse_queue[$];
   int mismatches = 0;
   longint cycles = 0;
   bit stall_enable = 1'b1;

   matrix3_inverse_adjugate u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [31:0] quotient_sat(longint num, longint det, ref bit clip);
      longint q;
      q = (num * 64'sd16777216) / det;
      if (q > 64'sd2147483647) begin
         q = 64'sd2147483647;
         clip = 1'b1;
      end else if (q < -64'sd2147483648) begin
         q = -64'sd2147483648;
         clip = 1'b1;
      end
      return q[31:0];
   endfunction

   function automatic logic [289:0] invert_matrix(logic [143:0] mat);
      longint m[3][3];
      longint adj[3][3];
      longint det;
      bit clip;
      logic [289:0] res;
      clip = 1'b0;
      res = '0;
      for (int c = 0; c < 3; c++)
         for (int r = 0; r < 3; r++)
            m[r][c] = longint'($signed(mat[(c*3+r)*16 +: 16]));
      adj[0][0] = m[1][1]*m[2][2] - m[1][2]*m[2][1];
      adj[0][1] = m[0][2]*m[2][1] - m[0][1]*m[2][2];
      adj[0][2] = m[0][1]*m[1][2] - m[0][2]*m[1][1];
      adj[1][0] = m[1][2]*m[2][0] - m[1][0]*m[2][2];
      adj[1][1] = m[0][0]*m[2][2] - m[0][2]*m[2][0];
      adj[1][2] = m[0][2]*m[1][0] - m[0][0]*m[1][2];
      adj[2][0] = m[1][0]*m[2][1] - m[1][1]*m[2][0];
      adj[2][1] = m[0][1]*m[2][0] - m[0][0]*m[2][1];
      adj[2][2] = m[0][0]*m[1][1] - m[0][1]*m[1][0];
      det = m[0][0]*adj[0][0] + m[0][1]*adj[1][0] + m[0][2]*adj[2][0];
      if (det == 0) begin
         res[288] = 1'b1;
         return res;
      end
      for (int c = 0; c < 3; c++)
         for (int r = 0; r < 3; r++)
            res[(c*3+r)*32 +: 32] = quotient_sat(adj[r][c], det, clip);
      res[289] = clip;
      return res;
   endfunction

   function automatic int random_gap();
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
      if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
      return 0;
   endfunction

   task automatic send_matrix(logic [143:0] mat);
      int gap;
      gap = stall_enable ? random_gap() : 0;
      repeat (gap) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= mat;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      inverse_queue.push_back(invert_matrix(mat));
      @(negedge clock);
   endtask

   function automatic logic [15:0] random_elem();
      case ($urandom_range(0, 5))
         0: return 16'h7fff;
         1: return 16'h8000;
         2: return 16'($urandom_range(0, 15)) - 16'd8;
         3: return 16'($urandom_range(0, 1023)) - 16'd512;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [143:0] random_matrix();
      logic [143:0] mat;
      for (int i = 0; i < 9; i++) mat[i*16 +: 16] = random_elem();
      return mat;
   endfunction

   function automatic logic [143:0] diag_matrix(logic [15:0] a, logic [15:0] b,
                                                logic [15:0] c);
      logic [143:0] mat;
      mat = '0;
      mat[0 +: 16] = a;
      mat[64 +: 16] = b;
      mat[128 +: 16] = c;
      return mat;
   endfunction

   // identity, scaled identities, extremes and singular cases
   task automatic test_directed();
      logic [143:0] mat;
      send_matrix(diag_matrix(16'h0100, 16'h0100, 16'h0100));
      send_matrix(diag_matrix(16'h0200, 16'hff00, 16'h0080));
      send_matrix(diag_matrix(16'h0001, 16'h0001, 16'h0001));
      send_matrix(diag_matrix(16'h7fff, 16'h7fff, 16'h7fff));
      send_matrix(diag_matrix(16'h8000, 16'h8000, 16'h8000));
      send_matrix(diag_matrix(16'h8000, 16'h7fff, 16'h0001));
      send_matrix(diag_matrix(16'h0001, 16'h0001, 16'h8000));
      send_matrix('0);
      send_matrix({144{1'b1}});
      send_matrix({9{16'h7fff}});
      send_matrix({9{16'h8000}});
      send_matrix(diag_matrix(16'h0100, 16'h0100, 16'h0000));
      mat = '0;
      for (int i = 0; i < 9; i++) mat[i*16 +: 16] = 16'(i + 1) << 8;
      send_matrix(mat);
      mat[128 +: 16] = 16'h0a00;
      send_matrix(mat);
      // permutation matrix, negative determinant
      mat = '0;
      mat[16 +: 16] = 16'h0100;
      mat[48 +: 16] = 16'h0100;
      mat[128 +: 16] = 16'h0100;
      send_matrix(mat);
      send_matrix(diag_matrix(16'h0003, 16'h0007, 16'hfffb));
      send_matrix(diag_matrix(16'h5555, 16'haaaa, 16'h0101));
   endtask

   task automatic test_random(int count);
      logic [143:0] mat;
      for (int n = 0; n < count; n++) begin
         mat = random_matrix();
         // some rank-deficient matrices: copy one column onto another
         if ($urandom_range(0, 9) == 0)
            mat[($urandom_range(0, 2))*48 +: 48] = mat[($urandom_range(0, 2))*48 +: 48];
         send_matrix(mat);
      end
   endtask

   task automatic test_back_to_back(int count);
      stall_enable = 1'b0;
      test_random(count);
      stall_enable = 1'b1;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(900);
      test_back_to_back(400);
      req_tvalid <= 1'b0;
      while (inverse_queue.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (mismatches == 0 && inverse_queue.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // receiver stalls
   initial begin
      int gap;
      @(negedge clock);
      while (1) begin
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 60)) @(negedge clock);
         gap = random_gap();
         if (gap != 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      logic [289:0] want;
      cycles <= cycles + 1;
      if (cycles > MAX_CYCLES) begin
         $display("end of test: mismatches");
         $finish;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (inverse_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected transfer: %h %b", rsp_tdata, rsp_tuser);
         end else begin
            want = inverse_queue.pop_front();
            for (int i = 0; i < 9; i++)
               if (rsp_tdata[i*32 +: 32] !== want[i*32 +: 32]) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("element %0d: expected %h actual %h", i,
                              want[i*32 +: 32], rsp_tdata[i*32 +: 32]);
               end
            if (rsp_tuser[0] !== want[288] || rsp_tuser[1] !== want[289]) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("flags singular/clipped: expected %b%b actual %b%b",
                           want[288], want[289], rsp_tuser[0], rsp_tuser[1]);
            end
         end
      end
   end
endmodule
